// ===== rtl/core/besc_pkg.sv =====
// shared types and constants for the evidence score combiner
// used by besc_row_cell, besc_div_cell and the top level
package besc_pkg;

    localparam int FIELD_W = 17;
    localparam int IDX_W   = 3;
    localparam int N_REGS  = 6;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_POS_MZ    = 3'd0;
    localparam logic [IDX_W-1:0] REG_NEG_MZ    = 3'd1;
    localparam logic [IDX_W-1:0] REG_POS_RT    = 3'd2;
    localparam logic [IDX_W-1:0] REG_NEG_RT    = 3'd3;
    localparam logic [IDX_W-1:0] REG_POS_SCORE = 3'd4;
    localparam logic [IDX_W-1:0] REG_NEG_SCORE = 3'd5;

    // sideband that travels with every word down the pipe
    typedef struct packed {
        logic               valid;
        logic               skip;
        logic [FIELD_W-1:0] raw;
    } t_side;

endpackage

// ===== rtl/core/besc_row_cell.sv =====
// one evidence cell: forms the positive and negative table rows and folds them
// into the running products; depends on besc_pkg
module besc_row_cell #(
    parameter int FRAC_BITS = 16,
    parameter int CELL      = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  besc_pkg::t_side              i_side,
    input  logic [2:0][FRAC_BITS:0]      i_ev,
    input  logic [FRAC_BITS:0]           i_ap,
    input  logic [FRAC_BITS:0]           i_an,
    input  logic [FRAC_BITS:0]           i_acc_pos,
    input  logic [FRAC_BITS:0]           i_acc_neg,
    output besc_pkg::t_side              o_side,
    output logic [2:0][FRAC_BITS:0]      o_ev,
    output logic [FRAC_BITS:0]           o_acc_pos,
    output logic [FRAC_BITS:0]           o_acc_neg
);
    import besc_pkg::*;

    localparam int PW  = FRAC_BITS + 1;
    localparam int PW2 = 2 * PW;
    localparam logic [PW-1:0] ONE_P = {1'b1, {FRAC_BITS{1'b0}}};

    logic [PW-1:0]     ev;
    logic [PW2-1:0]    n_pp_pos, n_qq_pos, n_pp_neg, n_qq_neg;
    logic [PW2-1:0]    r_pp_pos, r_qq_pos, r_pp_neg, r_qq_neg;
    t_side             r1_side, r2_side;
    logic [2:0][PW-1:0] r1_ev, r2_ev;
    logic [PW-1:0]     r1_acc_pos, r1_acc_neg;
    logic [PW2-1:0]    sum_pos, sum_neg;
    logic [PW-1:0]     row_pos, row_neg;
    logic [PW2-1:0]    prod_pos, prod_neg;
    logic [PW-1:0]     r2_acc_pos, r2_acc_neg;

    assign ev = i_ev[CELL];

    // stage 1: a*p and (1-a)*(1-p) for both classes
    assign n_pp_pos = PW2'(i_ap) * PW2'(ev);
    assign n_qq_pos = PW2'(ONE_P - i_ap) * PW2'(ONE_P - ev);
    assign n_pp_neg = PW2'(i_an) * PW2'(ev);
    assign n_qq_neg = PW2'(ONE_P - i_an) * PW2'(ONE_P - ev);

    // stage 2: row value, then scale the running product
    assign sum_pos  = r_pp_pos + r_qq_pos;
    assign sum_neg  = r_pp_neg + r_qq_neg;
    assign row_pos  = PW'(sum_pos >> FRAC_BITS);
    assign row_neg  = PW'(sum_neg >> FRAC_BITS);
    assign prod_pos = PW2'(r1_acc_pos) * PW2'(row_pos);
    assign prod_neg = PW2'(r1_acc_neg) * PW2'(row_neg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_side <= '0;
            r2_side <= '0;
        end else if (i_en) begin
            r1_side <= i_side;
            r2_side <= r1_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp_pos   <= n_pp_pos;
            r_qq_pos   <= n_qq_pos;
            r_pp_neg   <= n_pp_neg;
            r_qq_neg   <= n_qq_neg;
            r1_ev      <= i_ev;
            r1_acc_pos <= i_acc_pos;
            r1_acc_neg <= i_acc_neg;
            r2_ev      <= r1_ev;
            r2_acc_pos <= PW'(prod_pos >> FRAC_BITS);
            r2_acc_neg <= PW'(prod_neg >> FRAC_BITS);
        end
    end

    assign o_side    = r2_side;
    assign o_ev      = r2_ev;
    assign o_acc_pos = r2_acc_pos;
    assign o_acc_neg = r2_acc_neg;

endmodule

// ===== rtl/core/besc_div_cell.sv =====
// one restoring division cell: settles one quotient bit of pos / (pos + neg)
// depends on besc_pkg
module besc_div_cell #(
    parameter int FRAC_BITS = 16,
    parameter bit FIRST     = 1'b0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  besc_pkg::t_side      i_side,
    input  logic [FRAC_BITS+1:0] i_rem,
    input  logic [FRAC_BITS+1:0] i_den,
    input  logic [FRAC_BITS:0]   i_quo,
    input  logic                 i_degen,
    output besc_pkg::t_side      o_side,
    output logic [FRAC_BITS+1:0] o_rem,
    output logic [FRAC_BITS+1:0] o_den,
    output logic [FRAC_BITS:0]   o_quo,
    output logic                 o_degen
);
    import besc_pkg::*;

    localparam int PW = FRAC_BITS + 1;
    localparam int RW = PW + 1;

    logic [RW-1:0] trial;
    logic          ge;
    t_side         r_side;
    logic [RW-1:0] r_rem, r_den;
    logic [PW-1:0] r_quo;
    logic          r_degen;

    // the numerator's low bits are zero, so later cells shift in zeros
    assign trial = FIRST ? i_rem : {i_rem[RW-2:0], 1'b0};
    assign ge    = (trial >= i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem   <= ge ? (trial - i_den) : trial;
            r_den   <= i_den;
            r_quo   <= {i_quo[PW-2:0], ge};
            r_degen <= i_degen;
        end
    end

    assign o_side  = r_side;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_quo   = r_quo;
    assign o_degen = r_degen;

endmodule

// ===== rtl/core/bayes_evidence_score_combiner.sv =====
// top level of the naive bayes evidence score combiner
// depends on besc_pkg, besc_row_cell and besc_div_cell
//
// Usage:
// - input channel (i_in_valid / o_in_ready) takes one word per hit: three
//   probabilities in Q1.FRAC_BITS and a flag telling whether the m/z and
//   retention time values exist
// - output channel (o_out_valid / i_out_ready) returns one word per input word,
//   in order: posterior, the old score, skipped and degenerate flags
// - configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data),
//   one conditional table entry per index; unknown indexes are dropped,
//   values above one are clamped to one when written
// - throughput is one word per cycle while the skid register is empty; the path
//   runs through one input register, two stages in each of the three evidence
//   cells, one sum stage, FRAC_BITS + 1 division cells and one output register
// - the divider is a chain of restoring cells, one quotient bit each
// - a stalled receiver parks one word in a skid register; the pipe freezes
//   and o_in_ready drops only while that skid register is full
// - synchronous reset empties the pipe and loads the default table
module bayes_evidence_score_combiner #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [besc_pkg::FIELD_W-1:0]  i_mz_prob,
    input  logic [besc_pkg::FIELD_W-1:0]  i_rt_prob,
    input  logic [besc_pkg::FIELD_W-1:0]  i_search_score,
    input  logic                          i_side_values_present,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [besc_pkg::FIELD_W-1:0]  o_new_score,
    output logic [besc_pkg::FIELD_W-1:0]  o_old_score,
    output logic                          o_skipped,
    output logic                          o_degenerate,
    input  logic                          i_cfg_we,
    input  logic [besc_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [besc_pkg::FIELD_W-1:0]  i_cfg_data
);
    import besc_pkg::*;

    localparam int PW = FRAC_BITS + 1;
    localparam int RW = PW + 1;
    localparam int XW = (PW > FIELD_W) ? PW : FIELD_W;
    localparam logic [XW-1:0] ONE_X = XW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] ONE_P = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [63:0] ONE64 = 64'd1 << FRAC_BITS;
    localparam logic [63:0] MASK64 = (64'd1 << FIELD_W) - 64'd1;
    localparam logic [63:0] DEF9 = ((ONE64 * 64'd9) / 64'd10) & MASK64;
    localparam logic [63:0] DEF7 = ((ONE64 * 64'd7) / 64'd10) & MASK64;
    localparam logic [PW-1:0] RST_HI = PW'((DEF9 > ONE64) ? ONE64 : DEF9);
    localparam logic [PW-1:0] RST_MID = PW'((DEF7 > ONE64) ? ONE64 : DEF7);

    function automatic logic [PW-1:0] sat_one(input logic [FIELD_W-1:0] v);
        logic [XW-1:0] x;
        x = XW'(v);
        return (x > ONE_X) ? PW'(ONE_X) : PW'(x);
    endfunction

    logic                 en;
    logic [PW-1:0]        r_cfg [N_REGS];
    t_side                r_in_side;
    logic [2:0][PW-1:0]   r_in_ev;

    t_side                side_r [4];
    logic [2:0][PW-1:0]   ev_r [3];
    logic [PW-1:0]        pos_r [4];
    logic [PW-1:0]        neg_r [4];

    t_side                r_den_side;
    logic [RW-1:0]        r_den;
    logic [PW-1:0]        r_pos;
    logic                 r_degen;

    t_side                side_c [PW+1];
    logic [RW-1:0]        rem_c [PW+1];
    logic [RW-1:0]        den_c [PW+1];
    logic [PW-1:0]        quo_c [PW+1];
    logic                 degen_c [PW+1];

    t_side                fin_side;
    logic [FIELD_W-1:0]   n_new;
    logic                 n_degen;

    logic                 r_out_valid, r_out_skip, r_out_degen;
    logic [FIELD_W-1:0]   r_out_new, r_out_old;
    logic                 r_skid_valid, r_skid_skip, r_skid_degen;
    logic [FIELD_W-1:0]   r_skid_new, r_skid_old;

    assign en         = !r_skid_valid;
    assign o_in_ready = en;

    // configuration table, stored already clamped to one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_POS_MZ]    <= RST_HI;
            r_cfg[REG_NEG_MZ]    <= '0;
            r_cfg[REG_POS_RT]    <= RST_MID;
            r_cfg[REG_NEG_RT]    <= '0;
            r_cfg[REG_POS_SCORE] <= RST_HI;
            r_cfg[REG_NEG_SCORE] <= '0;
        end else if (i_cfg_we && (i_cfg_idx < IDX_W'(N_REGS))) begin
            r_cfg[i_cfg_idx] <= sat_one(i_cfg_data);
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_side <= '0;
        end else if (en) begin
            r_in_side.valid <= i_in_valid;
            r_in_side.skip  <= !i_side_values_present;
            r_in_side.raw   <= i_search_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_ev[0] <= sat_one(i_mz_prob);
            r_in_ev[1] <= sat_one(i_rt_prob);
            r_in_ev[2] <= sat_one(i_search_score);
        end
    end

    assign side_r[0] = r_in_side;
    assign ev_r[0]   = r_in_ev;
    assign pos_r[0]  = ONE_P;
    assign neg_r[0]  = ONE_P;

    besc_row_cell #(.FRAC_BITS(FRAC_BITS), .CELL(0)) u_cell_mz (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_side(side_r[0]), .i_ev(ev_r[0]),
        .i_ap(r_cfg[REG_POS_MZ]), .i_an(r_cfg[REG_NEG_MZ]),
        .i_acc_pos(pos_r[0]), .i_acc_neg(neg_r[0]),
        .o_side(side_r[1]), .o_ev(ev_r[1]),
        .o_acc_pos(pos_r[1]), .o_acc_neg(neg_r[1])
    );

    besc_row_cell #(.FRAC_BITS(FRAC_BITS), .CELL(1)) u_cell_rt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_side(side_r[1]), .i_ev(ev_r[1]),
        .i_ap(r_cfg[REG_POS_RT]), .i_an(r_cfg[REG_NEG_RT]),
        .i_acc_pos(pos_r[1]), .i_acc_neg(neg_r[1]),
        .o_side(side_r[2]), .o_ev(ev_r[2]),
        .o_acc_pos(pos_r[2]), .o_acc_neg(neg_r[2])
    );

    besc_row_cell #(.FRAC_BITS(FRAC_BITS), .CELL(2)) u_cell_score (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_side(side_r[2]), .i_ev(ev_r[2]),
        .i_ap(r_cfg[REG_POS_SCORE]), .i_an(r_cfg[REG_NEG_SCORE]),
        .i_acc_pos(pos_r[2]), .i_acc_neg(neg_r[2]),
        .o_side(side_r[3]), .o_ev(),
        .o_acc_pos(pos_r[3]), .o_acc_neg(neg_r[3])
    );

    // denominator stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_den_side <= '0;
        end else if (en) begin
            r_den_side <= side_r[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den   <= RW'(pos_r[3]) + RW'(neg_r[3]);
            r_pos   <= pos_r[3];
            r_degen <= (pos_r[3] == '0) && (neg_r[3] == '0);
        end
    end

    assign side_c[0]  = r_den_side;
    assign rem_c[0]   = RW'(r_pos);
    assign den_c[0]   = r_den;
    assign quo_c[0]   = '0;
    assign degen_c[0] = r_degen;

    // quotient bits from the top (weight one) down to the last fraction bit
    for (genvar k = 0; k < PW; k++) begin : g_div
        besc_div_cell #(.FRAC_BITS(FRAC_BITS), .FIRST(k == 0)) u_div (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_side(side_c[k]), .i_rem(rem_c[k]), .i_den(den_c[k]),
            .i_quo(quo_c[k]), .i_degen(degen_c[k]),
            .o_side(side_c[k+1]), .o_rem(rem_c[k+1]), .o_den(den_c[k+1]),
            .o_quo(quo_c[k+1]), .o_degen(degen_c[k+1])
        );
    end

    assign fin_side = side_c[PW];
    assign n_degen  = !fin_side.skip && degen_c[PW];
    always_comb begin
        if (fin_side.skip) begin
            n_new = fin_side.raw;
        end else if (degen_c[PW]) begin
            n_new = '0;
        end else begin
            n_new = FIELD_W'(quo_c[PW]);
        end
    end

    // output register with one skid word behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid  <= r_skid_valid || fin_side.valid;
            r_skid_valid <= 1'b0;
        end else if (en && fin_side.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out_new   <= r_skid_new;
                r_out_old   <= r_skid_old;
                r_out_skip  <= r_skid_skip;
                r_out_degen <= r_skid_degen;
            end else begin
                r_out_new   <= n_new;
                r_out_old   <= fin_side.raw;
                r_out_skip  <= fin_side.skip;
                r_out_degen <= n_degen;
            end
        end else if (en) begin
            r_skid_new   <= n_new;
            r_skid_old   <= fin_side.raw;
            r_skid_skip  <= fin_side.skip;
            r_skid_degen <= n_degen;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_new_score  = r_out_new;
    assign o_old_score  = r_out_old;
    assign o_skipped    = r_out_skip;
    assign o_degenerate = r_out_degen;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with empty output register");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && en && fin_side.valid) |=> !o_in_ready)
        else $error("pipe kept running with output and skid both occupied");

    a_skip_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_skipped) |-> (o_new_score == o_old_score && !o_degenerate))
        else $error("skipped word altered");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_degenerate) |-> (o_new_score == '0))
        else $error("degenerate word with nonzero score");

    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_side.valid && !degen_c[PW]) |-> (rem_c[PW] < den_c[PW]))
        else $error("division remainder not below denominator");

endmodule
